/* hw/rtl/bgsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsc_pkg
// Shared types, register map and charge curve function for the battery
// gauge with shutdown countdown.
// ----------------------------------------------------------------------------
package bgsc_pkg;

  localparam int unsigned MV_W        = 16;
  localparam int unsigned LEVEL_W     = 14;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned X_STEP_BITS = 7;
  localparam int unsigned DIVIDEND_W  = MV_W + X_STEP_BITS;
  localparam int unsigned DIVISOR_W   = MV_W;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = '0;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 14'd10000;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 14'd100;

  localparam logic [MV_W-1:0]    MAX_MV_RST    = 16'd4200;
  localparam logic [MV_W-1:0]    MIN_MV_RST    = 16'd3300;
  localparam logic [MV_W-1:0]    CUTOFF_MV_RST = 16'd3000;
  localparam logic [COUNT_W-1:0] RELOAD_RST    = 8'd5;

  typedef enum logic [2:0] {
    REG_MAX_MV    = 3'd0,
    REG_MIN_MV    = 3'd1,
    REG_CUTOFF_MV = 3'd2,
    REG_RATIO     = 3'd3,
    REG_RELOAD    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MV_W-1:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic [MV_W-1:0]    scaled_voltage_mv;
    logic [LEVEL_W-1:0] level_hundredths;
    logic               reading_valid;
    logic [COUNT_W-1:0] countdown_left;
    logic               shutdown_request;
  } out_t;

  typedef struct packed {
    logic [MV_W-1:0]    max_mv;
    logic [MV_W-1:0]    min_mv;
    logic [MV_W-1:0]    cutoff_mv;
    logic [MV_W-1:0]    ratio;
    logic [COUNT_W-1:0] reload;
  } cfg_t;

  // Curve entry i, worked in Q16 arithmetic: 101 - 101/(1+(1.33x)^4.5)^3, x = i/128,
  // scaled to hundredths and clipped to full. Evaluated at elaboration.
  function automatic logic [LEVEL_W-1:0] curve_entry(int unsigned i);
    longint unsigned t, t2, t4, s, u, w, w2, w3, n, q, r, lvl, rem, bitv;
    int k;
    t   = (64'd133 * 64'(i) * 64'd65536 + 64'd6400) / 64'd12800;
    t2  = (t * t + 64'd32768) >> 16;
    t4  = (t2 * t2 + 64'd32768) >> 16;
    rem = t << 16;
    s   = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= s + bitv) begin
        rem = rem - (s + bitv);
        s   = (s >> 1) + bitv;
      end else begin
        s = s >> 1;
      end
      bitv = bitv >> 2;
    end
    u = (t4 * s + 64'd32768) >> 16;
    if (u >= 64'd262144) begin
      return LEVEL_FULL;
    end
    w  = 64'd65536 + u;
    w2 = (w * w + 64'd32768) >> 16;
    w3 = (w2 * w + 64'd32768) >> 16;
    n  = 64'd10100 * 64'd65536 + (w3 >> 1);
    q  = 0;
    r  = 0;
    for (k = 63; k >= 0; k--) begin
      r = (r << 1) | ((n >> k) & 64'd1);
      if (r >= w3) begin
        r = r - w3;
        q = q | (64'd1 << k);
      end
    end
    lvl = 64'd10100 - q;
    if (lvl > 64'd10000) begin
      lvl = 64'd10000;
    end
    return LEVEL_W'(lvl);
  endfunction

endpackage

/* hw/rtl/bgsc_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsc_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface bgsc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/bgsc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsc_regs
// APB configuration registers: voltage thresholds, divider ratio and
// countdown reload value.
// ----------------------------------------------------------------------------
module bgsc_regs #(
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bgsc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bgsc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bgsc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output bgsc_pkg::cfg_t                       cfg_o,
  output logic                                 reload_wr_o
);
  import bgsc_pkg::*;

  localparam logic [MV_W-1:0] RATIO_RST = MV_W'(1 << RATIO_FRAC_BITS);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_mv    <= MAX_MV_RST;
      cfg_q.min_mv    <= MIN_MV_RST;
      cfg_q.cutoff_mv <= CUTOFF_MV_RST;
      cfg_q.ratio     <= RATIO_RST;
      cfg_q.reload    <= RELOAD_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_MV:    cfg_q.max_mv    <= pwdata[MV_W-1:0];
        REG_MIN_MV:    cfg_q.min_mv    <= pwdata[MV_W-1:0];
        REG_CUTOFF_MV: cfg_q.cutoff_mv <= pwdata[MV_W-1:0];
        REG_RATIO:     cfg_q.ratio     <= pwdata[MV_W-1:0];
        REG_RELOAD:    cfg_q.reload    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MAX_MV:    prdata = APB_DATA_W'(cfg_q.max_mv);
      REG_MIN_MV:    prdata = APB_DATA_W'(cfg_q.min_mv);
      REG_CUTOFF_MV: prdata = APB_DATA_W'(cfg_q.cutoff_mv);
      REG_RATIO:     prdata = APB_DATA_W'(cfg_q.ratio);
      REG_RELOAD:    prdata = APB_DATA_W'(cfg_q.reload);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o       = cfg_q;
  assign reload_wr_o = wr_en && (idx == REG_RELOAD);

endmodule

/* hw/rtl/bgsc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsc_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgsc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [bgsc_pkg::DIVIDEND_W-1:0]    dividend_i,
  input  logic [bgsc_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [bgsc_pkg::DIVIDEND_W-1:0]    quotient_o
);
  import bgsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign fits  = !diff[DIVISOR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/bgsc_curve_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsc_curve_rom
// Charge curve table, indexed in steps of 1/128 of the voltage span,
// with registered read data.
// ----------------------------------------------------------------------------
module bgsc_curve_rom #(
  parameter int unsigned CURVE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(CURVE_ENTRIES)-1:0]    addr_i,
  output logic [bgsc_pkg::LEVEL_W-1:0]        data_o
);
  import bgsc_pkg::*;

  logic [LEVEL_W-1:0] rom_w [CURVE_ENTRIES];
  logic [LEVEL_W-1:0] data_q;

  for (genvar g = 0; g < CURVE_ENTRIES; g++) begin : g_entry
    localparam logic [LEVEL_W-1:0] ENTRY = curve_entry(g);
    assign rom_w[g] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* hw/rtl/battery_gauge_shutdown_countdown.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_shutdown_countdown
// Battery gauge: scales a raw sample to millivolts, maps it onto the charge
// curve and runs the low-battery shutdown countdown.
// ----------------------------------------------------------------------------
// One sample is in work at a time. A reading between minimum and the curve
// end runs the 23-step serial divider that forms the curve index and then
// reads the curve table; a reading past the curve end skips the table read,
// and a reading below minimum, or a flat or inverted span, skips the divider.
// The result waits in an output register, so the next sample is taken while
// it is still pending.
module battery_gauge_shutdown_countdown #(
  parameter int unsigned CURVE_ENTRIES   = 256,
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bgsc_stream_if.sink                        in_i,
  bgsc_stream_if.source                      out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bgsc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bgsc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bgsc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import bgsc_pkg::*;

  localparam int unsigned IDX_W = $clog2(CURVE_ENTRIES);
  localparam int unsigned PROD_W = 2 * MV_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CMP  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ROM  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  cfg_t               cfg;
  logic               reload_wr;
  logic [MV_W-1:0]    raw_q;
  logic [MV_W-1:0]    volt_q;
  logic [LEVEL_W-1:0] level_q;
  logic [COUNT_W-1:0] count_q;
  logic               latch_q;
  out_t               out_q;
  logic               out_valid_q;

  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_sh;
  logic [MV_W-1:0]       volt_sat;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic [MV_W-1:0]       offset;
  logic [MV_W-1:0]       span;
  logic                  beyond;
  logic                  rom_rd;
  logic [LEVEL_W-1:0]    rom_data;
  logic                  emit;
  logic                  valid_rd;
  logic [COUNT_W-1:0]    count_next;

  bgsc_regs #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .reload_wr_o (reload_wr)
  );

  bgsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({offset, X_STEP_BITS'(0)}),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  bgsc_curve_rom #(
    .CURVE_ENTRIES (CURVE_ENTRIES)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (rom_rd),
    .addr_i  (quotient[IDX_W-1:0]),
    .data_o  (rom_data)
  );

  assign prod     = PROD_W'(raw_q) * PROD_W'(cfg.ratio);
  assign prod_sh  = prod >> RATIO_FRAC_BITS;
  assign volt_sat = (|prod_sh[PROD_W-1:MV_W]) ? '1 : prod_sh[MV_W-1:0];

  assign offset    = volt_q - cfg.min_mv;
  assign span      = cfg.max_mv - cfg.min_mv;
  assign beyond    = quotient >= DIVIDEND_W'(CURVE_ENTRIES);
  assign div_start = (state_q == S_CMP) && (volt_q >= cfg.min_mv)
                     && (cfg.max_mv > cfg.min_mv);
  assign rom_rd    = (state_q == S_DIV) && div_done && !beyond;
  assign emit      = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign valid_rd   = volt_q >= cfg.cutoff_mv;
  assign count_next = (level_q > LEVEL_LOW) ? cfg.reload
                    : (count_q != '0) ? count_q - 1'b1 : '0;

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_MUL;
      S_MUL:  state_d = S_CMP;
      S_CMP:  state_d = div_start ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_d = beyond ? S_DONE : S_ROM;
      S_ROM:  state_d = S_DONE;
      S_DONE: if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= RELOAD_RST;
      latch_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (reload_wr) begin
        count_q <= pwdata[COUNT_W-1:0];
      end else if (emit && valid_rd) begin
        count_q <= count_next;
        if (count_next == '0) begin
          latch_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      raw_q <= in_i.payload.raw_reading;
    end
    if (state_q == S_MUL) begin
      volt_q <= volt_sat;
    end
    if (state_q == S_CMP) begin
      if (volt_q < cfg.min_mv) begin
        level_q <= LEVEL_EMPTY;
      end else if (cfg.max_mv <= cfg.min_mv) begin
        level_q <= LEVEL_FULL;
      end
    end
    if ((state_q == S_DIV) && div_done && beyond) begin
      level_q <= LEVEL_FULL;
    end
    if (state_q == S_ROM) begin
      level_q <= rom_data;
    end
    if (emit) begin
      out_q.scaled_voltage_mv <= volt_q;
      out_q.level_hundredths  <= level_q;
      out_q.reading_valid     <= valid_rd;
      out_q.countdown_left    <= valid_rd ? count_next : count_q;
      out_q.shutdown_request  <= latch_q || (valid_rd && (count_next == '0));
    end
  end

endmodule
